>>> rtl/rfmu_pkg.sv
`default_nettype none

package rfmu_pkg;

   // Number of threads that can be queued; one mask bit and one ring entry each.
   localparam int THREADS = 16;
   localparam int TID_W   = 4;
   localparam int RING_W  = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int FILL_W  = $clog2(THREADS + 1);
   localparam int COUNT_W = 16;

   typedef enum logic [1:0] {
      OP_LOCK    = 2'd0,
      OP_TRYLOCK = 2'd1,
      OP_UNLOCK  = 2'd2,
      OP_DESTROY = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_WAIT      = 3'd1,
      ST_BUSY      = 3'd2,
      ST_NOT_OWNER = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

   typedef struct packed {
      op_type           op;
      logic [TID_W-1:0] thread_id;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic             wake_valid;
      logic [TID_W-1:0] wake_thread;
   } rsp_type;

   // Queue commands from the lock controller; push and pop never coincide.
   typedef struct packed {
      logic             push;
      logic             pop;
      logic             clear;
      logic [TID_W-1:0] push_thread;
   } queue_cmd_type;

   // Queue view for the request under decision.
   typedef struct packed {
      logic             empty;
      logic             full;
      logic [TID_W-1:0] head_thread;
      logic             tid_queued;
   } queue_stat_type;

endpackage

`default_nettype wire

>>> rtl/rfmu_wait_queue.sv
`default_nettype none

module rfmu_wait_queue (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [rfmu_pkg::TID_W-1:0]     lookup_thread,
   input  wire rfmu_pkg::queue_cmd_type        cmd,
   output      rfmu_pkg::queue_stat_type       stat
);
   import rfmu_pkg::*;

   logic [TID_W-1:0]  ring_ff [THREADS];
   logic [RING_W-1:0] head_ff, head_in;
   logic [RING_W-1:0] tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [THREADS-1:0] mask_ff, mask_in;
   logic [TID_W-1:0]  head_thread;

   function automatic logic [RING_W-1:0] next_ptr(input logic [RING_W-1:0] ptr);
      logic [RING_W-1:0] nxt;
      if (ptr == RING_W'(THREADS - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

   assign head_thread = ring_ff[head_ff];

   assign stat.empty       = (fill_ff == '0);
   assign stat.full        = (fill_ff == FILL_W'(THREADS));
   assign stat.head_thread = head_thread;
   assign stat.tid_queued  = mask_ff[RING_W'(lookup_thread)];

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      mask_in = mask_ff;
      if (cmd.clear) begin
         head_in = '0;
         tail_in = '0;
         fill_in = '0;
         mask_in = '0;
      end else if (cmd.push) begin
         tail_in = next_ptr(tail_ff);
         fill_in = fill_ff + 1'b1;
         mask_in[RING_W'(cmd.push_thread)] = 1'b1;
      end else if (cmd.pop) begin
         head_in = next_ptr(head_ff);
         fill_in = fill_ff - 1'b1;
         mask_in[RING_W'(head_thread)] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
         mask_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
         mask_ff <= mask_in;
      end
   end

   // Ring entries are only read while the queue holds them, so they need no reset.
   always_ff @(posedge clock) begin
      if (cmd.push && !cmd.clear) begin
         ring_ff[tail_ff] <= cmd.push_thread;
      end
   end

endmodule

`default_nettype wire

>>> rtl/rfmu_lock_ctrl.sv
`default_nettype none

module rfmu_lock_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       fire,
   input  wire rfmu_pkg::req_type          req,
   input  wire rfmu_pkg::queue_stat_type   qstat,
   output      rfmu_pkg::queue_cmd_type    qcmd,
   output      rfmu_pkg::rsp_type          result
);
   import rfmu_pkg::*;

   logic                owner_valid_ff, owner_valid_in;
   logic [TID_W-1:0]    owner_thread_ff, owner_thread_in;
   logic [COUNT_W-1:0]  nest_count_ff, nest_count_in;

   logic owned;
   logic at_max;
   logic head_match;
   logic tid_out_of_range;

   assign owned            = owner_valid_ff && (owner_thread_ff == req.thread_id);
   assign at_max           = (nest_count_ff == '1);
   assign head_match       = !qstat.empty && (qstat.head_thread == req.thread_id);
   assign tid_out_of_range = (32'(req.thread_id) >= THREADS);

   always_comb begin
      owner_valid_in     = owner_valid_ff;
      owner_thread_in    = owner_thread_ff;
      nest_count_in      = nest_count_ff;
      qcmd               = '0;
      qcmd.push_thread   = req.thread_id;
      result.status      = ST_OK;
      result.wake_valid  = 1'b0;
      result.wake_thread = '0;

      case (req.op)
         OP_LOCK, OP_TRYLOCK: begin
            if (owned) begin
               if (at_max) begin
                  result.status = ST_OVERFLOW;
               end else begin
                  nest_count_in = nest_count_ff + 1'b1;
               end
            end else if (!owner_valid_ff && (qstat.empty || head_match)) begin
               // A free mutex goes to the requester if nobody waits ahead of it.
               qcmd.pop        = head_match;
               owner_valid_in  = 1'b1;
               owner_thread_in = req.thread_id;
               nest_count_in   = COUNT_W'(1);
            end else if (req.op == OP_TRYLOCK || tid_out_of_range) begin
               result.status = ST_BUSY;
            end else begin
               qcmd.push     = !qstat.tid_queued && !qstat.full;
               result.status = ST_WAIT;
            end
         end
         OP_UNLOCK: begin
            if (owned) begin
               if (nest_count_ff <= COUNT_W'(1)) begin
                  owner_valid_in     = 1'b0;
                  owner_thread_in    = '0;
                  nest_count_in      = '0;
                  result.wake_valid  = !qstat.empty;
                  result.wake_thread = qstat.empty ? '0 : qstat.head_thread;
               end else begin
                  nest_count_in = nest_count_ff - 1'b1;
               end
            end else begin
               result.status = ST_NOT_OWNER;
            end
         end
         OP_DESTROY: begin
            if (qstat.empty) begin
               qcmd.clear      = 1'b1;
               owner_valid_in  = 1'b0;
               owner_thread_in = '0;
               nest_count_in   = '0;
            end else begin
               result.status = ST_BUSY;
            end
         end
         default: begin
            result.status = ST_BUSY;
         end
      endcase

      // Nothing changes unless a request is actually executed this cycle.
      if (!fire) begin
         owner_valid_in  = owner_valid_ff;
         owner_thread_in = owner_thread_ff;
         nest_count_in   = nest_count_ff;
         qcmd.push       = 1'b0;
         qcmd.pop        = 1'b0;
         qcmd.clear      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_valid_ff  <= 1'b0;
         owner_thread_ff <= '0;
         nest_count_ff   <= '0;
      end else begin
         owner_valid_ff  <= owner_valid_in;
         owner_thread_ff <= owner_thread_in;
         nest_count_ff   <= nest_count_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/recursive_fifo_mutex_unit.sv
`default_nettype none

// Lock unit for one recursive mutex shared by up to sixteen numbered threads, with a
// first-in first-out queue of waiting threads. Each request (lock, trylock, unlock or
// destroy from one thread) produces exactly one result: a status, and on the final
// unlock of a contended mutex the thread at the head of the queue that should be woken.
// A request is registered on transfer and decided once the result register can take it,
// against the owner, nesting count and queue registers, which are updated in that same
// cycle; the decision is registered as the result. The unit takes one request per clock
// unless results stall; a stalled result holds the decision stage, which then stalls the
// request channel. The thread is woken by the caller; the unit leaves the woken thread
// queued until it retries its lock, at which point it is popped and made owner.
module recursive_fifo_mutex_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire rfmu_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      rfmu_pkg::rsp_type rsp_data
);
   import rfmu_pkg::*;

   logic           stage_valid_ff, stage_valid_in;
   req_type        stage_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff;
   logic           exec_load;
   logic           req_accept;
   logic           fire;
   queue_cmd_type  qcmd;
   queue_stat_type qstat;
   rsp_type        result;

   assign exec_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = stage_valid_ff && !exec_load;
   assign req_accept = req_valid && !req_stall;
   assign fire       = stage_valid_ff && exec_load;

   assign stage_valid_in = req_accept ? 1'b1 : (exec_load ? 1'b0 : stage_valid_ff);
   assign rsp_valid_in   = exec_load ? stage_valid_ff : rsp_valid_ff;

   rfmu_wait_queue u_queue (
      .clock         (clock),
      .reset         (reset),
      .lookup_thread (stage_ff.thread_id),
      .cmd           (qcmd),
      .stat          (qstat)
   );

   rfmu_lock_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .req    (stage_ff),
      .qstat  (qstat),
      .qcmd   (qcmd),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/rfmu_checker.sv
`default_nettype none

module rfmu_port_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire rfmu_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire rfmu_pkg::rsp_type rsp_data
);
   import rfmu_pkg::*;

   // A wake-up is only ever reported by a successful final unlock.
   a_wake_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.wake_valid |-> rsp_data.status == ST_OK)
      else $error("wake reported with a non-ok status");

   a_no_wake_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.wake_valid |-> rsp_data.wake_thread == '0)
      else $error("wake thread set without a wake");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed or dropped");

   // With the result side empty, the request side can never be stalled.
   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while the result register is empty");

endmodule

bind recursive_fifo_mutex_unit rfmu_port_checker u_rfmu_port_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
